@@ rtl/assert_macros.svh @@
// Assertion macros shared by the step counter RTL.
// Depends on nothing; files that assert include it by name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on a named clock with a named synchronous reset.
`define SPVC_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on the block's own clock and reset.
`define SPVC_ASSERT_CLK(label, prop, msg) \
   `SPVC_ASSERT(label, clock, reset, prop, msg)

`endif

@@ rtl/spvc_pkg.sv @@
// Package for the peak/valley step counter: widths, reset values, CSR codes,
// shared structs and the acceleration absolute-value helper. Depends on nothing.
package spvc_pkg;

   localparam int ACCEL_W   = 14;
   localparam int MAG_W     = 15;
   localparam int SENS_W    = 15;
   localparam int TIMEOUT_W = 8;
   localparam int CONFIRM_W = 3;
   localparam int TOTAL_W   = 32;
   localparam int STREAK_W  = 3;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 15;

   localparam int WINDOW_LEN_DEF  = 17;
   localparam int AVG_TAPS_DEF    = 4;
   localparam int THRESH_TAPS_DEF = 4;
   localparam int FIFO_DEPTH      = 8;

   localparam logic [SENS_W-1:0]    SENS_RESET    = SENS_W'(1700);
   localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = TIMEOUT_W'(50);
   localparam logic [CONFIRM_W-1:0] CONFIRM_RESET = CONFIRM_W'(4);
   localparam logic [MAG_W-1:0]     THRESH_INIT   = MAG_W'(4000);
   localparam logic [STREAK_W-1:0]  STREAK_MAX    = '1;
   localparam logic [TIMEOUT_W-1:0] SINCE_MAX     = '1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SENSITIVITY    = 2'd0,
      CSR_VALLEY_TIMEOUT = 2'd1,
      CSR_CONFIRM_STEPS  = 2'd2
   } spvc_csr_type;

   typedef struct packed {
      logic ge;
      logic le;
   } spvc_cmp_type;

   typedef struct packed {
      logic [SENS_W-1:0]    sensitivity;
      logic [TIMEOUT_W-1:0] valley_timeout;
      logic [CONFIRM_W-1:0] confirm_steps;
   } spvc_cfg_type;

   typedef struct packed {
      logic [TOTAL_W-1:0]   total_steps;
      logic [MAG_W-1:0]     centre_level;
      logic [CONFIRM_W-1:0] steps_added;
      logic                 window_ready;
   } spvc_rsp_type;

   function automatic logic [ACCEL_W-1:0] accel_abs(input logic [ACCEL_W-1:0] v);
      return v[ACCEL_W-1] ? ACCEL_W'(~v + 1'b1) : v;
   endfunction

endpackage

@@ rtl/step_counter_peak_valley.sv @@
// Step counter top level: magnitude and averaging stages, the window cell
// chain, the tracker and the response queue. Uses spvc_pkg, spvc_cell, spvc_track.
//
// Usage:
//   req_* carries one three-axis acceleration sample per transaction; rsp_*
//   returns exactly one result per sample, in order. csr_* writes sensitivity,
//   valley_timeout and confirm_steps; write them only while no transaction is
//   outstanding.
//   Pipeline: each result passes one pipeline register each for the magnitude,
//   the moving-average sum and the window shift, then the detection is written
//   into the response queue, from which it is offered.
//   Throughput: one sample per cycle while rsp_ready stays high; the window
//   shift is done by all cells at once and the centre compares are combinational.
//   Stall: up to 8 transactions may be outstanding (the response queue depth);
//   req_ready drops when 8 are accepted and not yet delivered.
//   Reset: synchronous; clears the pipeline, the queue, the window, the
//   averages (threshold back to 4000) and the step total, and restores the
//   register defaults. No clearing pass is needed.
`include "assert_macros.svh"

module step_counter_peak_valley import spvc_pkg::*; #(
   parameter int WINDOW_LEN  = WINDOW_LEN_DEF,
   parameter int AVG_TAPS    = AVG_TAPS_DEF,
   parameter int THRESH_TAPS = THRESH_TAPS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic signed [ACCEL_W-1:0]  req_accel_x,
   input  logic signed [ACCEL_W-1:0]  req_accel_y,
   input  logic signed [ACCEL_W-1:0]  req_accel_z,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [TOTAL_W-1:0]         rsp_total_steps,
   output logic [MAG_W-1:0]           rsp_centre_level,
   output logic [CONFIRM_W-1:0]       rsp_steps_added,
   output logic                       rsp_window_ready,
   input  logic                       csr_write_enable,
   input  logic [CSR_IDX_W-1:0]       csr_index,
   input  logic [CSR_DATA_W-1:0]      csr_write_data
);

   localparam int CentrePos = WINDOW_LEN / 2;
   localparam int FillW     = $clog2(WINDOW_LEN + 1);
   localparam int SlotW     = $clog2(AVG_TAPS);
   localparam int MagSumW   = MAG_W + SlotW;
   localparam int DivShift  = MagSumW + SlotW;
   localparam int RecipW    = MagSumW + 1;
   localparam int ProdW     = MagSumW + RecipW;
   localparam longint AvgRecip = ((longint'(1) << DivShift) + AVG_TAPS - 1) / AVG_TAPS;
   localparam logic [SlotW-1:0] SlotLast = SlotW'(AVG_TAPS - 1);
   localparam int PtrW = $clog2(FIFO_DEPTH);
   localparam int CntW = $clog2(FIFO_DEPTH + 1);

   spvc_cfg_type cfg_ff;

   logic               req_fire, rsp_fire;
   logic               mag_valid_ff, sum_valid_ff, win_valid_ff;
   logic [MAG_W-1:0]   mag_ff;
   logic [MAG_W-1:0]   mag_ring_ff [AVG_TAPS];
   logic [MagSumW-1:0] mag_sum_ff, mag_sum_in;
   logic [SlotW-1:0]   mag_slot_ff;
   logic [ProdW-1:0]   avg_prod;
   logic [MAG_W-1:0]   level;
   logic [FillW-1:0]   fill_count_ff;
   logic               win_ready;

   logic [MAG_W-1:0]   tap [WINDOW_LEN+1];
   spvc_cmp_type       cmp [WINDOW_LEN];
   logic [WINDOW_LEN-1:0] ge_vec, le_vec;
   logic               is_max, is_min;
   spvc_rsp_type       trk_rsp;

   spvc_rsp_type       fifo_mem [FIFO_DEPTH];
   logic [PtrW-1:0]    wr_ptr_ff, rd_ptr_ff;
   logic [CntW-1:0]    fifo_count_ff, inflight_ff;
   spvc_rsp_type       rsp_head;

   assign req_fire = req_valid && req_ready;
   assign rsp_fire = rsp_valid && rsp_ready;
   assign req_ready = inflight_ff < CntW'(FIFO_DEPTH);

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sensitivity    <= SENS_RESET;
         cfg_ff.valley_timeout <= TIMEOUT_RESET;
         cfg_ff.confirm_steps  <= CONFIRM_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_SENSITIVITY:    cfg_ff.sensitivity    <= csr_write_data[SENS_W-1:0];
            CSR_VALLEY_TIMEOUT: cfg_ff.valley_timeout <= csr_write_data[TIMEOUT_W-1:0];
            CSR_CONFIRM_STEPS:  cfg_ff.confirm_steps  <= csr_write_data[CONFIRM_W-1:0];
            default: ;
         endcase
      end
   end

   // magnitude, moving-average sum, window shift
   assign mag_sum_in = mag_sum_ff - MagSumW'(mag_ring_ff[mag_slot_ff]) + MagSumW'(mag_ff);
   assign avg_prod   = ProdW'(mag_sum_ff) * ProdW'(AvgRecip);
   assign level      = avg_prod[DivShift +: MAG_W];

   always_ff @(posedge clock) begin
      if (reset) begin
         mag_valid_ff  <= 1'b0;
         sum_valid_ff  <= 1'b0;
         win_valid_ff  <= 1'b0;
         mag_sum_ff    <= '0;
         mag_slot_ff   <= '0;
         fill_count_ff <= '0;
         for (int i = 0; i < AVG_TAPS; i++) begin
            mag_ring_ff[i] <= '0;
         end
      end else begin
         mag_valid_ff <= req_fire;
         sum_valid_ff <= mag_valid_ff;
         win_valid_ff <= sum_valid_ff;
         if (mag_valid_ff) begin
            mag_sum_ff                <= mag_sum_in;
            mag_ring_ff[mag_slot_ff]  <= mag_ff;
            mag_slot_ff <= (mag_slot_ff == SlotLast) ? '0 : mag_slot_ff + 1'b1;
         end
         if (sum_valid_ff && fill_count_ff != FillW'(WINDOW_LEN)) begin
            fill_count_ff <= fill_count_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         mag_ff <= MAG_W'(accel_abs(req_accel_x)) + MAG_W'(accel_abs(req_accel_y)) +
                   MAG_W'(accel_abs(req_accel_z));
      end
   end

   // window cell chain, newest level enters at the top
   assign tap[WINDOW_LEN] = level;

   for (genvar i = 0; i < WINDOW_LEN; i++) begin : g_cell
      spvc_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .shift_en  (sum_valid_ff),
         .level_in  (tap[i+1]),
         .centre    (tap[CentrePos]),
         .level_out (tap[i]),
         .cmp       (cmp[i])
      );
      if (i == CentrePos) begin : g_centre
         assign ge_vec[i] = 1'b0;
         assign le_vec[i] = 1'b0;
      end else begin : g_side
         assign ge_vec[i] = cmp[i].ge;
         assign le_vec[i] = cmp[i].le;
      end
   end

   assign is_max    = ~|ge_vec;
   assign is_min    = ~|le_vec;
   assign win_ready = fill_count_ff == FillW'(WINDOW_LEN);

   spvc_track #(
      .THRESH_TAPS (THRESH_TAPS)
   ) u_track (
      .clock     (clock),
      .reset     (reset),
      .fire      (win_valid_ff),
      .win_ready (win_ready),
      .centre    (tap[CentrePos]),
      .is_max    (is_max),
      .is_min    (is_min),
      .cfg       (cfg_ff),
      .rsp       (trk_rsp)
   );

   // response queue and outstanding-transaction count
   always_ff @(posedge clock) begin
      if (win_valid_ff) begin
         fifo_mem[wr_ptr_ff] <= trk_rsp;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff     <= '0;
         rd_ptr_ff     <= '0;
         fifo_count_ff <= '0;
         inflight_ff   <= '0;
      end else begin
         if (win_valid_ff) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (rsp_fire) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         case ({win_valid_ff, rsp_fire})
            2'b10:   fifo_count_ff <= fifo_count_ff + 1'b1;
            2'b01:   fifo_count_ff <= fifo_count_ff - 1'b1;
            default: fifo_count_ff <= fifo_count_ff;
         endcase
         case ({req_fire, rsp_fire})
            2'b10:   inflight_ff <= inflight_ff + 1'b1;
            2'b01:   inflight_ff <= inflight_ff - 1'b1;
            default: inflight_ff <= inflight_ff;
         endcase
      end
   end

   assign rsp_head         = fifo_mem[rd_ptr_ff];
   assign rsp_valid        = fifo_count_ff != '0;
   assign rsp_total_steps  = rsp_head.total_steps;
   assign rsp_centre_level = rsp_head.centre_level;
   assign rsp_steps_added  = rsp_head.steps_added;
   assign rsp_window_ready = rsp_head.window_ready;

   `SPVC_ASSERT_CLK(a_credit_bound, inflight_ff <= CntW'(FIFO_DEPTH), "outstanding count over queue depth")
   `SPVC_ASSERT_CLK(a_queue_within_credit, fifo_count_ff <= inflight_ff, "queue holds more than outstanding")
   `SPVC_ASSERT_CLK(a_fill_saturates, fill_count_ff <= FillW'(WINDOW_LEN), "fill count past window length")
   `SPVC_ASSERT_CLK(a_no_steps_while_filling, win_valid_ff && !win_ready |-> trk_rsp.steps_added == '0, "steps credited before window full")

endmodule

@@ rtl/spvc_cell.sv @@
// One window cell: holds a filtered level, passes it to its older neighbor
// on each shift and compares it with the window centre. Uses spvc_pkg.
module spvc_cell import spvc_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             shift_en,
   input  logic [MAG_W-1:0] level_in,
   input  logic [MAG_W-1:0] centre,
   output logic [MAG_W-1:0] level_out,
   output spvc_cmp_type     cmp
);

   logic [MAG_W-1:0] level_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff <= '0;
      end else if (shift_en) begin
         level_ff <= level_in;
      end
   end

   assign level_out = level_ff;
   assign cmp.ge    = level_ff >= centre;
   assign cmp.le    = level_ff <= centre;

endmodule

@@ rtl/spvc_track.sv @@
// Peak/valley tracker: dynamic threshold average, streak and step total.
// Uses spvc_pkg; fed by the window cells of the top level.
module spvc_track import spvc_pkg::*; #(
   parameter int THRESH_TAPS = THRESH_TAPS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             fire,
   input  logic             win_ready,
   input  logic [MAG_W-1:0] centre,
   input  logic             is_max,
   input  logic             is_min,
   input  spvc_cfg_type     cfg,
   output spvc_rsp_type     rsp
);

   localparam int SlotW    = $clog2(THRESH_TAPS);
   localparam int SumW     = MAG_W + SlotW;
   localparam int DivShift = SumW + SlotW;
   localparam int RecipW   = SumW + 1;
   localparam int ProdW    = SumW + RecipW;
   localparam int CmpW     = MAG_W + 1;
   localparam longint DivRecip =
      ((longint'(1) << DivShift) + THRESH_TAPS - 1) / THRESH_TAPS;
   localparam logic [SumW-1:0]   SumInit  = SumW'(THRESH_INIT * THRESH_TAPS);
   localparam logic [SlotW-1:0]  SlotLast = SlotW'(THRESH_TAPS - 1);

   logic                 seeking_ff, seeking_in;
   logic [TIMEOUT_W-1:0] since_ff, since_in, since_inc;
   logic [MAG_W-1:0]     peak_ff, peak_in;
   logic [MAG_W-1:0]     thr_ring_ff [THRESH_TAPS];
   logic [MAG_W-1:0]     thr_ring_in [THRESH_TAPS];
   logic [SumW-1:0]      thr_sum_ff, thr_sum_in, thr_sum_upd;
   logic [SlotW-1:0]     thr_slot_ff, thr_slot_in;
   logic [MAG_W-1:0]     thr_mean_ff, thr_mean_in, mean_upd, mean_use;
   logic                 miss_ff, miss_in;
   logic [STREAK_W-1:0]  streak_ff, streak_in, streak_sat;
   logic [STREAK_W:0]    streak_next;
   logic [TOTAL_W-1:0]   total_ff, total_in;
   logic [CONFIRM_W-1:0] added;
   logic [MAG_W-1:0]     fresh;
   logic [ProdW-1:0]     mean_prod;
   logic [SENS_W-2:0]    half;
   logic                 drop_ok, hit;

   assign half        = cfg.sensitivity[SENS_W-1:1];
   assign since_inc   = (seeking_ff && since_ff != SINCE_MAX) ? since_ff + 1'b1 : since_ff;
   assign drop_ok     = CmpW'(peak_ff) > CmpW'(centre) + CmpW'(cfg.sensitivity);
   assign fresh       = MAG_W'((CmpW'(peak_ff) + CmpW'(centre)) >> 1);
   assign thr_sum_upd = thr_sum_ff - SumW'(thr_ring_ff[thr_slot_ff]) + SumW'(fresh);
   assign mean_prod   = ProdW'(thr_sum_upd) * ProdW'(DivRecip);
   assign mean_upd    = mean_prod[DivShift +: MAG_W];
   assign mean_use    = drop_ok ? mean_upd : thr_mean_ff;
   assign hit         = (CmpW'(peak_ff) > CmpW'(mean_use) + CmpW'(half)) &&
                        (CmpW'(centre) + CmpW'(half) < CmpW'(mean_use));
   assign streak_sat  = (streak_ff == STREAK_MAX) ? streak_ff : streak_ff + 1'b1;
   assign streak_next = (STREAK_W+1)'(streak_ff) + 1'b1;

   always_comb begin
      seeking_in  = seeking_ff;
      since_in    = since_ff;
      peak_in     = peak_ff;
      thr_ring_in = thr_ring_ff;
      thr_sum_in  = thr_sum_ff;
      thr_slot_in = thr_slot_ff;
      thr_mean_in = thr_mean_ff;
      miss_in     = miss_ff;
      streak_in   = streak_ff;
      added       = '0;
      if (fire && win_ready) begin
         since_in = since_inc;
         if (!seeking_ff) begin
            if (is_max) begin
               peak_in    = centre;
               seeking_in = 1'b1;
               since_in   = '0;
            end
         end else if (is_min) begin
            if (drop_ok) begin
               thr_ring_in[thr_slot_ff] = fresh;
               thr_sum_in  = thr_sum_upd;
               thr_slot_in = (thr_slot_ff == SlotLast) ? '0 : thr_slot_ff + 1'b1;
               thr_mean_in = mean_upd;
            end
            if (hit) begin
               miss_in   = 1'b0;
               streak_in = streak_sat;
               if (streak_next == (STREAK_W+1)'(cfg.confirm_steps)) begin
                  added = cfg.confirm_steps;
               end else if (CONFIRM_W'(streak_ff) >= cfg.confirm_steps) begin
                  added = CONFIRM_W'(1);
               end
            end else if (miss_ff) begin
               miss_in   = 1'b0;
               streak_in = '0;
            end else begin
               miss_in = 1'b1;
            end
            seeking_in = 1'b0;
         end else if (since_inc > cfg.valley_timeout) begin
            streak_in  = '0;
            seeking_in = 1'b0;
         end
      end
      total_in = fire ? total_ff + TOTAL_W'(added) : total_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seeking_ff  <= 1'b0;
         since_ff    <= '0;
         peak_ff     <= '0;
         for (int i = 0; i < THRESH_TAPS; i++) begin
            thr_ring_ff[i] <= THRESH_INIT;
         end
         thr_sum_ff  <= SumInit;
         thr_slot_ff <= '0;
         thr_mean_ff <= THRESH_INIT;
         miss_ff     <= 1'b0;
         streak_ff   <= '0;
         total_ff    <= '0;
      end else begin
         seeking_ff  <= seeking_in;
         since_ff    <= since_in;
         peak_ff     <= peak_in;
         thr_ring_ff <= thr_ring_in;
         thr_sum_ff  <= thr_sum_in;
         thr_slot_ff <= thr_slot_in;
         thr_mean_ff <= thr_mean_in;
         miss_ff     <= miss_in;
         streak_ff   <= streak_in;
         total_ff    <= total_in;
      end
   end

   assign rsp.total_steps  = total_in;
   assign rsp.centre_level = centre;
   assign rsp.steps_added  = added;
   assign rsp.window_ready = win_ready;

endmodule
